@@ rtl/core/pse_pkg.sv @@
// ----------------------------------------------------------------------------
// pse_pkg: shared constants for the printable string extractor
// Register indexes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int CHAR_W         = 8;    // low/high byte and char_value width
    localparam int CFG_IDX_W      = 1;    // two configuration registers
    localparam int CFG_DATA_W     = 5;    // widest register (min_length)
    localparam int MIN_LEN_W      = 5;
    localparam int DEF_MAX_MIN_LENGTH = 16;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = MIN_LEN_W'(5);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = CFG_IDX_W'(1);

    // printable range
    localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7E;

endpackage

@@ rtl/core/pse_if.sv @@
// ----------------------------------------------------------------------------
// pse_if: request channels of the printable string extractor
// Input channel carries code units, output channel carries result items.
// ----------------------------------------------------------------------------
interface pse_in_if;
    logic                       valid;
    logic                       ready;
    logic [pse_pkg::CHAR_W-1:0] low_byte;
    logic [pse_pkg::CHAR_W-1:0] high_byte;
    logic                       end_of_data;

    modport source (output valid, low_byte, high_byte, end_of_data, input ready);
    modport sink   (input valid, low_byte, high_byte, end_of_data, output ready);
endinterface

interface pse_out_if;
    logic                       valid;
    logic                       ready;
    logic [pse_pkg::CHAR_W-1:0] char_value;
    logic                       char_present;
    logic                       string_end;
    logic                       last_of_burst;

    modport source (output valid, char_value, char_present, string_end, last_of_burst,
                    input ready);
    modport sink   (input valid, char_value, char_present, string_end, last_of_burst,
                    output ready);
endinterface

@@ rtl/core/pse_run_buffer.sv @@
// ----------------------------------------------------------------------------
// pse_run_buffer: character store for the head of a printable run
// One write port, one registered read port (write-first on an address match);
// no reset (entries are only read after being written in the current run).
// ----------------------------------------------------------------------------
module pse_run_buffer #(
    parameter int DEPTH = pse_pkg::DEF_MAX_MIN_LENGTH
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [pse_pkg::CHAR_W-1:0]       i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [pse_pkg::CHAR_W-1:0]       o_rdata
);

    logic [pse_pkg::CHAR_W-1:0] r_mem [DEPTH];
    logic [pse_pkg::CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // a read of the entry written at the same edge returns the new byte
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/printable_string_extractor.sv @@
// ----------------------------------------------------------------------------
// printable_string_extractor: printable-run extraction, strings style
// Finds runs of printable code units and reports those of min_length or more.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one code unit per request (low_byte, high_byte, end_of_data).
//   o_out  : result requests (char_value, char_present, string_end,
//            last_of_burst). last_of_burst marks the final result of one unit.
//   cfg    : i_cfg_we / i_cfg_idx / i_cfg_data, index 0 = wide_mode,
//            index 1 = min_length; write only while the block is idle.
// Output: each unit's first result is loaded into the output register at the
//   clock edge that accepts the unit.
// Throughput: one unit per cycle while o_out is not held off and no burst is
//   in progress. A unit that completes a run of min_length (m) characters
//   puts m results through the output register; i_in.ready stays low until
//   the last result of that burst is loaded. The first result is buffer entry
//   0, the rest are read from the run buffer, one entry per cycle while o_out
//   is not held off (the buffer read is registered, its address is the next burst index).
// Reset (synchronous, active low): wide_mode = 0, min_length = 5, run count
//   zero, output empty. The run buffer is not cleared.
// Stall: when o_out is held off, the output register keeps its result and
//   i_in.ready drops; no result is lost or repeated.
// ----------------------------------------------------------------------------
module printable_string_extractor #(
    parameter int MAX_MIN_LENGTH = pse_pkg::DEF_MAX_MIN_LENGTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pse_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pse_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pse_in_if.sink                          i_in,
    pse_out_if.source                       o_out
);

    localparam int CNT_W = $clog2(MAX_MIN_LENGTH + 1);   // holds 0..MAX
    localparam int IDX_W = $clog2(MAX_MIN_LENGTH);       // buffer address
    localparam int CMP_W = (CNT_W > pse_pkg::MIN_LEN_W) ? CNT_W : pse_pkg::MIN_LEN_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_MIN_LENGTH);

    // ---------------- configuration registers ----------------
    logic                           r_wide_mode;
    logic [pse_pkg::MIN_LEN_W-1:0]  r_min_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode  <= 1'b0;
            r_min_length <= pse_pkg::MIN_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pse_pkg::CFG_WIDE_MODE:  r_wide_mode  <= i_cfg_data[0];
                pse_pkg::CFG_MIN_LENGTH: r_min_length <= i_cfg_data[pse_pkg::MIN_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective threshold: zero reads as 1, clamp to the buffer depth
    logic [CMP_W-1:0] min_ext;
    logic [CNT_W-1:0] thresh;

    always_comb begin
        min_ext = CMP_W'(r_min_length);
        priority if (min_ext == '0) begin
            thresh = CNT_W'(1);
        end else if (min_ext > MAX_CMP) begin
            thresh = CNT_W'(MAX_MIN_LENGTH);
        end else begin
            thresh = min_ext[CNT_W-1:0];
        end
    end

    // ---------------- state ----------------
    logic [CNT_W-1:0]            r_run_count,    n_run_count;
    logic                        r_burst_active, n_burst_active;
    logic [CNT_W-1:0]            r_burst_idx,    n_burst_idx;
    logic [CNT_W-1:0]            r_burst_end,    n_burst_end;
    logic                        r_burst_eod,    n_burst_eod;

    logic                        r_out_valid,    n_out_valid;
    logic [pse_pkg::CHAR_W-1:0]  r_out_char,     n_out_char;
    logic                        r_out_present,  n_out_present;
    logic                        r_out_end,      n_out_end;
    logic                        r_out_last,     n_out_last;

    // run buffer ports
    logic                        buf_we;
    logic [IDX_W-1:0]            buf_waddr;
    logic [IDX_W-1:0]            buf_raddr;
    logic [pse_pkg::CHAR_W-1:0]  buf_rdata;

    logic out_free;
    logic accept;
    logic printable;
    logic under_thresh;
    logic burst_last;

    // output register can load when empty or being drained this cycle
    assign out_free     = !r_out_valid || o_out.ready;
    assign i_in.ready   = out_free && !r_burst_active;
    assign accept       = i_in.valid && i_in.ready;

    assign printable    = (!r_wide_mode || (i_in.high_byte == '0))
                          && (i_in.low_byte >= pse_pkg::PRINT_LO)
                          && (i_in.low_byte <= pse_pkg::PRINT_HI);
    assign under_thresh = r_run_count < thresh;

    // the run head is written at the current count while it is below threshold
    assign buf_we    = accept && printable && under_thresh;
    assign buf_waddr = r_run_count[IDX_W-1:0];
    // read address from the next burst state: the next burst entry, entry 0 otherwise
    assign buf_raddr = n_burst_active ? n_burst_idx[IDX_W-1:0] : '0;
    assign burst_last = (r_burst_idx == r_burst_end);

    pse_run_buffer #(
        .DEPTH (MAX_MIN_LENGTH)
    ) u_run_buffer (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (i_in.low_byte),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    always_comb begin
        n_run_count    = r_run_count;
        n_burst_active = r_burst_active;
        n_burst_idx    = r_burst_idx;
        n_burst_end    = r_burst_end;
        n_burst_eod    = r_burst_eod;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_char     = r_out_char;
        n_out_present  = r_out_present;
        n_out_end      = r_out_end;
        n_out_last     = r_out_last;

        if (r_burst_active && out_free) begin
            // continue the threshold burst from the buffer
            n_out_valid   = 1'b1;
            n_out_char    = buf_rdata;
            n_out_present = 1'b1;
            n_out_end     = burst_last && r_burst_eod;
            n_out_last    = burst_last;
            n_burst_idx   = r_burst_idx + CNT_W'(1);
            if (burst_last) begin
                n_burst_active = 1'b0;
            end
        end else if (accept) begin
            if (printable) begin
                if (under_thresh) begin
                    n_run_count = r_run_count + CNT_W'(1);
                    if ((r_run_count + CNT_W'(1)) == thresh) begin
                        n_out_valid   = 1'b1;
                        n_out_present = 1'b1;
                        if (thresh == CNT_W'(1)) begin
                            // one-character threshold: the unit is the string
                            n_out_char = i_in.low_byte;
                            n_out_end  = i_in.end_of_data;
                            n_out_last = 1'b1;
                        end else begin
                            n_out_char     = buf_rdata;
                            n_out_end      = 1'b0;
                            n_out_last     = 1'b0;
                            n_burst_active = 1'b1;
                            n_burst_idx    = CNT_W'(1);
                            n_burst_end    = thresh - CNT_W'(1);
                            n_burst_eod    = i_in.end_of_data;
                        end
                    end
                end else begin
                    // run already reported: pass the character through
                    n_run_count   = thresh;
                    n_out_valid   = 1'b1;
                    n_out_char    = i_in.low_byte;
                    n_out_present = 1'b1;
                    n_out_end     = i_in.end_of_data;
                    n_out_last    = 1'b1;
                end
                if (i_in.end_of_data) begin
                    n_run_count = '0;
                end
            end else begin
                // non-printable: bare terminator if a string was open
                if (!under_thresh) begin
                    n_out_valid   = 1'b1;
                    n_out_char    = '0;
                    n_out_present = 1'b0;
                    n_out_end     = 1'b1;
                    n_out_last    = 1'b1;
                end
                n_run_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count    <= '0;
            r_burst_active <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_run_count    <= n_run_count;
            r_burst_active <= n_burst_active;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload and burst bookkeeping carry no reset
    always_ff @(posedge i_clk) begin
        r_burst_idx   <= n_burst_idx;
        r_burst_end   <= n_burst_end;
        r_burst_eod   <= n_burst_eod;
        r_out_char    <= n_out_char;
        r_out_present <= n_out_present;
        r_out_end     <= n_out_end;
        r_out_last    <= n_out_last;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.char_value    = r_out_char;
    assign o_out.char_present  = r_out_present;
    assign o_out.string_end    = r_out_end;
    assign o_out.last_of_burst = r_out_last;

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_count <= CNT_W'(MAX_MIN_LENGTH))
        else $error("run count beyond buffer depth");

    a_burst_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst_active |-> (r_burst_idx <= r_burst_end))
        else $error("burst index past burst end");

    a_bare_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_present) |-> (r_out_end && r_out_last && r_out_char == '0))
        else $error("malformed bare terminator");

    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_burst_active) |-> (r_out_valid && !r_out_last))
        else $error("burst started without its first result");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (!r_burst_active && (!r_out_valid || o_out.ready)))
        else $error("unit accepted while output busy");

endmodule

@@ bench/pse_result_checker.sv @@
// ----------------------------------------------------------------------------
// pse_result_checker: scoreboard for the printable string extractor
// Watches the unit and result channels and the register port. Keeps its own
// copy of the run state, predicts the results of every accepted unit and
// compares accepted results against them in order.
// ----------------------------------------------------------------------------
module pse_result_checker
    import pse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pse_in_if                     i_in_mon,
    pse_out_if                    i_out_mon,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              present;
        logic              str_end;
        logic              last;
    } pse_result_t;

    localparam int RUN_DEPTH = DEF_MAX_MIN_LENGTH;
    localparam int RUN_IDX_W = $clog2(RUN_DEPTH);

    // mirrored registers and run state
    logic                 wide_q;
    logic [MIN_LEN_W-1:0] min_len_q;
    logic [CHAR_W-1:0]    run_chars [RUN_DEPTH];
    logic [MIN_LEN_W:0]   run_len;

    pse_result_t expected_chars[$];
    int          fail_cnt;

    // register value 0 acts as 1, values past the buffer depth saturate
    function automatic int threshold(input logic [MIN_LEN_W-1:0] raw);
        int m;
        m = int'(raw);
        if (m == 0)
            m = 1;
        if (m > RUN_DEPTH)
            m = RUN_DEPTH;
        return m;
    endfunction

    function automatic void predict_unit(input logic [CHAR_W-1:0] lo,
                                         input logic [CHAR_W-1:0] hi,
                                         input logic eod);
        pse_result_t burst [RUN_DEPTH];
        int          n;
        int          m;
        logic        printable;
        n = 0;
        m = threshold(min_len_q);
        printable = (!wide_q || hi == '0) && lo >= PRINT_LO && lo <= PRINT_HI;
        if (printable) begin
            if (int'(run_len) < m) begin
                run_chars[run_len[RUN_IDX_W-1:0]] = lo;
                run_len = run_len + (MIN_LEN_W+1)'(1);
                if (int'(run_len) == m) begin
                    for (int i = 0; i < m; i++) begin
                        burst[n] = '{ch: run_chars[i], present: 1'b1, str_end: 1'b0,
                                     last: 1'b0};
                        n++;
                    end
                end
            end else begin
                // already reported: run length pins at the threshold
                run_len = (MIN_LEN_W+1)'(m);
                burst[n] = '{ch: lo, present: 1'b1, str_end: 1'b0, last: 1'b0};
                n++;
            end
            if (eod) begin
                if (n > 0)
                    burst[n-1].str_end = 1'b1;
                run_len = '0;
            end
        end else begin
            if (int'(run_len) >= m) begin
                burst[n] = '{ch: '0, present: 1'b0, str_end: 1'b1, last: 1'b0};
                n++;
            end
            run_len = '0;
        end
        if (n > 0)
            burst[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_chars.push_back(burst[i]);
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
            fail_cnt++;
        end
    endfunction

    initial begin
        fail_cnt     = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        pse_result_t want;
        if (!i_rst_n) begin
            wide_q    = 1'b0;
            min_len_q = MIN_LEN_RESET;
            run_len   = '0;
            expected_chars.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WIDE_MODE)
                    wide_q = i_cfg_data[0];
                else if (i_cfg_idx == CFG_MIN_LENGTH)
                    min_len_q = i_cfg_data[MIN_LEN_W-1:0];
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict_unit(i_in_mon.low_byte, i_in_mon.high_byte, i_in_mon.end_of_data);
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0h/%0b/%0b/%0b",
                             $time, i_out_mon.char_value, i_out_mon.char_present,
                             i_out_mon.string_end, i_out_mon.last_of_burst);
                    fail_cnt++;
                end else begin
                    want = expected_chars.pop_front();
                    check_field("char_value", want.ch, i_out_mon.char_value);
                    check_field("char_present", want.present, i_out_mon.char_present);
                    check_field("string_end", want.str_end, i_out_mon.string_end);
                    check_field("last_of_burst", want.last, i_out_mon.last_of_burst);
                end
            end
        end
        o_pending    <= expected_chars.size();
        o_fail_count <= fail_cnt;
    end

endmodule

@@ bench/printable_string_extractor_tb.sv @@
// ----------------------------------------------------------------------------
// printable_string_extractor_tb: top level of the extractor bench
// Drives code units and register writes into the block, paces the result
// side, and leaves prediction and comparison to pse_result_checker. A short
// directed pass covers the printable bounds, short runs, threshold bursts,
// end of data on both kinds of unit, wide mode and the odd min_length values;
// random phases then push well-formed runs mixed with noise.
// ----------------------------------------------------------------------------
module printable_string_extractor_tb;
    import pse_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RUN_DEPTH     = DEF_MAX_MIN_LENGTH;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_UNITS   = 36;    // at least 288 random units overall

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int cycle_count;

    // when set, neither side idles (full-rate stretches)
    logic quiet;

    // stimulus shaping only: mirror of what was last written
    logic                 cur_wide;
    logic [MIN_LEN_W-1:0] cur_min;

    pse_in_if  in_ch ();
    pse_out_if out_ch ();

    printable_string_extractor DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    pse_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hang or a lost result ends here.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    // Result side backpressure. Stalls land on any beat of a burst since
    // they are drawn independently of what the block is doing.
    initial begin : rx_pacing
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
                hold = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
            end
            @(posedge i_clk);
        end
    end

    // One unit request: optional idle gap, then hold valid until taken.
    // valid is only lowered when a gap follows, so back-to-back units keep
    // it high without a same-step drop and raise.
    task automatic send_unit(input logic [CHAR_W-1:0] lo, input logic [CHAR_W-1:0] hi,
                             input logic eod);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.low_byte    <= lo;
        in_ch.high_byte   <= hi;
        in_ch.end_of_data <= eod;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has been taken.
    // The checker publishes its count through a register, hence the first edge.
    // Units that cause no result may still be in flight, so settle after.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both registers are rewritten, only with the block idle. The run state
    // survives the write, which is what the lowered-threshold case needs.
    task automatic set_config(input logic wide, input logic [MIN_LEN_W-1:0] min_len);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WIDE_MODE;
        cfg_data <= CFG_DATA_W'(wide);
        @(posedge i_clk);
        cfg_idx  <= CFG_MIN_LENGTH;
        cfg_data <= CFG_DATA_W'(min_len);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_wide = wide;
        cur_min  = min_len;
    endtask

    initial begin : stimulus
        logic [MIN_LEN_W-1:0] phase_min [RAND_PHASES];
        logic                 phase_wide [RAND_PHASES];
        logic [CHAR_W-1:0]    lo;
        logic [CHAR_W-1:0]    hi;
        logic                 eod;
        int                   hint;
        int                   run_n;
        int                   sent;
        int                   kind;

        // everything known from time zero
        quiet             = 1'b0;
        cur_wide          = 1'b0;
        cur_min           = MIN_LEN_RESET;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_WIDE_MODE;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.low_byte    <= '0;
        in_ch.high_byte   <= '0;
        in_ch.end_of_data <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: reset settings (narrow, threshold 5) ----
        // run reaches 5 -> whole buffer leaves as one burst
        send_unit("H", 8'h00, 1'b0);
        send_unit("e", 8'hFF, 1'b0);   // high byte ignored in narrow mode
        send_unit("l", 8'h00, 1'b0);
        send_unit("l", 8'h00, 1'b0);
        send_unit(8'h20, 8'h00, 1'b0); // lowest printable completes the run
        send_unit(8'h7E, 8'h00, 1'b0); // highest printable, single result
        send_unit(8'h7F, 8'h00, 1'b0); // just above range -> bare terminator
        // short run is dropped without any result
        send_unit("a", 8'h00, 1'b0);
        send_unit(8'h1F, 8'h00, 1'b0); // just below range
        // end of data on a non-printable unit with nothing reported
        send_unit(8'hFF, 8'h00, 1'b1);

        // ---- directed: wide mode, threshold 1 ----
        set_config(1'b1, MIN_LEN_W'(1));
        send_unit("A", 8'h00, 1'b0);
        send_unit("B", 8'h80, 1'b0);   // nonzero high byte -> not printable
        send_unit("C", 8'h00, 1'b1);   // end of data on printable: char closes

        // ---- directed: threshold register zero acts as one ----
        set_config(1'b0, MIN_LEN_W'(0));
        send_unit("x", 8'h00, 1'b1);

        // ---- directed: threshold lowered under a run in progress ----
        set_config(1'b0, MIN_LEN_W'(5));
        send_unit("a", 8'h00, 1'b0);
        send_unit("b", 8'h00, 1'b0);
        send_unit("c", 8'h00, 1'b0);
        set_config(1'b0, MIN_LEN_W'(2));
        send_unit("d", 8'h00, 1'b0);   // run counts as reported: lone char
        send_unit(8'h00, 8'h00, 1'b0); // terminator

        // ---- random phases ----
        // extremes first (1, 16, saturating 31, zero), then assorted values
        phase_wide = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_min  = '{MIN_LEN_W'(1), MIN_LEN_W'(16), MIN_LEN_W'(31), MIN_LEN_W'(0),
                       MIN_LEN_W'(3), MIN_LEN_W'(20), MIN_LEN_W'(0), MIN_LEN_W'(0)};
        phase_min[6] = MIN_LEN_W'($urandom_range(1, 8));
        phase_min[7] = MIN_LEN_W'($urandom_range(0, 31));

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_config(phase_wide[p], phase_min[p]);
            quiet = (p == 2 || p == 5);
            hint  = (cur_min == 0) ? 1 : ((int'(cur_min) > RUN_DEPTH) ? RUN_DEPTH
                                                                       : int'(cur_min));
            sent = 0;
            while (sent < PHASE_UNITS) begin
                // printable run around the threshold, sometimes much longer
                run_n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(0, hint + 3);
                for (int k = 0; k < run_n; k++) begin
                    lo  = CHAR_W'($urandom_range(32'h20, 32'h7E));
                    hi  = cur_wide ? 8'h00 : CHAR_W'($urandom);
                    eod = ($urandom_range(0, 24) == 0);
                    send_unit(lo, hi, eod);
                    sent++;
                end
                // closing unit, or noise that may extend the run
                kind = $urandom_range(0, 3);
                case (kind)
                    0: lo = CHAR_W'($urandom_range(0, 32'h1F));
                    1: lo = CHAR_W'($urandom_range(32'h7F, 32'hFF));
                    2: lo = CHAR_W'($urandom);
                    default: lo = CHAR_W'($urandom_range(32'h20, 32'h7E));
                endcase
                if (!cur_wide)
                    hi = CHAR_W'($urandom);
                else if (kind == 3 || $urandom_range(0, 5) == 0)
                    hi = CHAR_W'($urandom_range(1, 255));
                else
                    hi = 8'h00;
                eod = ($urandom_range(0, 3) == 0);
                send_unit(lo, hi, eod);
                sent++;
            end
        end
        quiet = 1'b0;

        // all units are in; wait out every result plus the settle time
        drain_results();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ printable_string_extractor.f @@
rtl/core/pse_pkg.sv
rtl/core/pse_if.sv
rtl/core/pse_run_buffer.sv
rtl/core/printable_string_extractor.sv
bench/pse_result_checker.sv
bench/printable_string_extractor_tb.sv
